### hdl/filled_circle_span_generator_defines.svh
// ---------------------------------------------------------------------------
// Filled circle span generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FCSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FCSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fcsg_pkg.sv
// ---------------------------------------------------------------------------
// Filled circle span generator package
// Widths, controller states and the controller/datapath command types.
// ---------------------------------------------------------------------------
package fcsg_pkg;

  localparam int POS_W      = 12;
  localparam int RAD_W      = 6;
  localparam int COLOR_W    = 32;
  localparam int SPAN_W     = 14;
  localparam int SQ_W       = 11;
  localparam int ACC_W      = 12;
  localparam int ROOT_STEPS = 6;
  localparam int IDX_W      = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_UPPER,
    ST_LOWER
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic root_step;
    logic advance;
    logic emit_lower;
  } dp_cmd_t;

  typedef struct packed {
    logic radius_zero;
    logic root_last;
    logic last_row;
  } dp_stat_t;

endpackage

### hdl/fcsg_cmd_if.sv
// ---------------------------------------------------------------------------
// Draw command channel
// Valid/ready channel carrying one circle draw command per transaction.
// ---------------------------------------------------------------------------
interface fcsg_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [fcsg_pkg::POS_W-1:0]   center_x;
  logic [fcsg_pkg::POS_W-1:0]   center_y;
  logic [fcsg_pkg::RAD_W-1:0]   circle_radius;
  logic [fcsg_pkg::COLOR_W-1:0] fill_color;

  modport source (output valid, center_x, center_y, circle_radius, fill_color,
                  input ready);
  modport sink   (input valid, center_x, center_y, circle_radius, fill_color,
                  output ready);
endinterface

### hdl/fcsg_span_if.sv
// ---------------------------------------------------------------------------
// Span output channel
// Valid/ready channel carrying one horizontal span per transaction.
// ---------------------------------------------------------------------------
interface fcsg_span_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcsg_pkg::SPAN_W-1:0]  span_row;
  logic signed [fcsg_pkg::SPAN_W-1:0]  span_left;
  logic signed [fcsg_pkg::SPAN_W-1:0]  span_right;
  logic        [fcsg_pkg::COLOR_W-1:0] span_color;
  logic                                last_span;

  modport source (output valid, span_row, span_left, span_right, span_color,
                  last_span, input ready);
  modport sink   (input valid, span_row, span_left, span_right, span_color,
                  last_span, output ready);
endinterface

### hdl/fcsg_ctrl.sv
// ---------------------------------------------------------------------------
// Filled circle span generator controller
// Sequences square, iterative root and the two span transactions per row.
// ---------------------------------------------------------------------------
module fcsg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fcsg_pkg::dp_stat_t stat,
  output fcsg_pkg::dp_cmd_t  cmd
);
  import fcsg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !stat.radius_zero) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_ROOT;
      ST_ROOT: begin
        if (stat.root_last) begin
          state_next = ST_UPPER;
        end
      end
      ST_UPPER: begin
        if (out_ready) begin
          state_next = ST_LOWER;
        end
      end
      ST_LOWER: begin
        if (out_ready) begin
          state_next = stat.last_row ? ST_IDLE : ST_SQUARE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQUARE: cmd.square = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_UPPER:  out_valid = 1'b1;
      ST_LOWER: begin
        out_valid      = 1'b1;
        cmd.emit_lower = 1'b1;
        cmd.advance    = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/fcsg_datapath.sv
// ---------------------------------------------------------------------------
// Filled circle span generator datapath
// Command registers, row term, bitwise square root and span arithmetic.
// ---------------------------------------------------------------------------
module fcsg_datapath #(
  parameter int MAX_RADIUS = 32,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fcsg_pkg::dp_cmd_t                   cmd,
  output fcsg_pkg::dp_stat_t                  stat,
  input  logic [fcsg_pkg::POS_W-1:0]          center_x,
  input  logic [fcsg_pkg::POS_W-1:0]          center_y,
  input  logic [fcsg_pkg::RAD_W-1:0]          circle_radius,
  input  logic [fcsg_pkg::COLOR_W-1:0]        fill_color,
  output logic signed [fcsg_pkg::SPAN_W-1:0]  span_row,
  output logic signed [fcsg_pkg::SPAN_W-1:0]  span_left,
  output logic signed [fcsg_pkg::SPAN_W-1:0]  span_right,
  output logic [fcsg_pkg::COLOR_W-1:0]        span_color,
  output logic                                last_span
);
  import fcsg_pkg::*;

  localparam logic [RAD_W-1:0] R_MAX = RAD_W'(MAX_RADIUS);
  localparam logic [POS_W-1:0] COORD_MASK =
    (COORD_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << COORD_BITS) - 1);

  logic [POS_W-1:0]   held_center_x;
  logic [POS_W-1:0]   held_center_y;
  logic [RAD_W-1:0]   held_radius;
  logic [COLOR_W-1:0] held_color;
  logic [RAD_W-1:0]   row_step;
  logic [RAD_W-1:0]   half_width;
  logic [ACC_W-1:0]   rem;
  logic [ACC_W-1:0]   res;
  logic [IDX_W-1:0]   idx;

  logic [RAD_W-1:0]   radius_sat;
  logic [RAD_W:0]     span_factor;
  logic [SQ_W-1:0]    row_term;
  logic [ACC_W-1:0]   bit_val;
  logic [ACC_W-1:0]   trial;
  logic [ACC_W-1:0]   rem_next;
  logic [ACC_W-1:0]   res_next;

  assign radius_sat  = (circle_radius > R_MAX) ? R_MAX : circle_radius;
  assign span_factor = {held_radius, 1'b0} - {1'b0, row_step};
  assign row_term    = SQ_W'(row_step * span_factor);

  assign bit_val = ACC_W'(1) << {idx, 1'b0};
  assign trial   = res + bit_val;

  always_comb begin
    if (rem >= trial) begin
      rem_next = rem - trial;
      res_next = (res >> 1) + bit_val;
    end else begin
      rem_next = rem;
      res_next = res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      held_color    <= '0;
      row_step      <= '0;
      half_width    <= '0;
      rem           <= '0;
      res           <= '0;
      idx           <= '0;
    end else begin
      if (cmd.load) begin
        held_center_x <= center_x & COORD_MASK;
        held_center_y <= center_y & COORD_MASK;
        held_radius   <= radius_sat;
        held_color    <= fill_color;
        row_step      <= RAD_W'(1);
      end
      if (cmd.square) begin
        rem       <= ACC_W'(row_term);
        res       <= '0;
        idx       <= IDX_W'(ROOT_STEPS - 1);
      end
      if (cmd.root_step) begin
        rem <= rem_next;
        res <= res_next;
        idx <= idx - IDX_W'(1);
        if (idx == '0) begin
          half_width <= RAD_W'(res_next);
        end
      end
      if (cmd.advance && !stat.last_row) begin
        row_step <= row_step + RAD_W'(1);
      end
    end
  end

  logic signed [SPAN_W-1:0] cx_s, cy_s, d_s, r_s, h_s;

  assign cx_s = $signed(SPAN_W'(held_center_x));
  assign cy_s = $signed(SPAN_W'(held_center_y));
  assign d_s  = $signed(SPAN_W'(row_step));
  assign r_s  = $signed(SPAN_W'(held_radius));
  assign h_s  = $signed(SPAN_W'(half_width));

  assign span_row   = cmd.emit_lower ? (cy_s - d_s + r_s) : (cy_s + d_s - r_s);
  assign span_left  = cx_s - h_s;
  assign span_right = cx_s + h_s;
  assign span_color = held_color;
  assign last_span  = cmd.emit_lower && stat.last_row;

  assign stat.radius_zero = (circle_radius == '0);
  assign stat.root_last   = (idx == '0);
  assign stat.last_row    = (row_step == held_radius);

endmodule

### hdl/filled_circle_span_generator.sv
// ---------------------------------------------------------------------------
// Filled circle span generator
// Turns one circle draw command into 2*r horizontal spans, two per row step.
// ---------------------------------------------------------------------------
//   channel  dir  transaction
//   cmd      in   center_x, center_y, circle_radius, fill_color
//   span     out  span_row, span_left, span_right, span_color, last_span
//
// Per row step: the row term, then the bitwise square root, then 2 span
// transactions; r is saturated to MAX_RADIUS. A zero radius command is
// taken and yields no spans. Commands are taken only while idle. Reset is
// synchronous and returns the controller to idle. Span stalls hold the
// sequencer in place.
// ---------------------------------------------------------------------------
`include "filled_circle_span_generator_defines.svh"

module filled_circle_span_generator #(
  parameter int MAX_RADIUS = 32,
  parameter int COORD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  fcsg_cmd_if.sink    cmd,
  fcsg_span_if.source span
);
  import fcsg_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cmd_draw;
  logic     span_done;

  assign cmd_draw  = cmd.valid && cmd.ready && (cmd.circle_radius != '0);
  assign span_done = span.valid && span.ready && span.last_span;

  fcsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (span.valid),
    .out_ready (span.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  fcsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .center_x      (cmd.center_x),
    .center_y      (cmd.center_y),
    .circle_radius (cmd.circle_radius),
    .fill_color    (cmd.fill_color),
    .span_row      (span.span_row),
    .span_left     (span.span_left),
    .span_right    (span.span_right),
    .span_color    (span.span_color),
    .last_span     (span.last_span)
  );

  `FCSG_ASSERT_SAME(a_no_overlap, span.valid, !cmd.ready, "span valid while idle")
  `FCSG_ASSERT_NEXT(a_last_idle, span_done, cmd.ready, "not idle after last span")
  `FCSG_ASSERT_NEXT(a_busy_after_cmd, cmd_draw, !cmd.ready, "idle after nonzero command")

endmodule
